### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge of clock and
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold at any clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

// Whenever the trigger holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

`endif

### design/lirs_pkg.sv
// ---------------------------------------------------------------------------
// Linear interpolation resampler package
// Widths, register indexes and word types shared by the resampler modules.
// ---------------------------------------------------------------------------
`default_nettype none

package lirs_pkg;

   // Sample and phase widths.
   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = 16;
   localparam int PHASE_BITS  = FRAC_BITS + 3;
   localparam int MAX_OUTS    = 6;
   localparam int CNT_BITS    = 3;

   // Configuration port widths.
   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;

   // Phase constants in Q16.
   localparam logic [PHASE_BITS-1:0] PHASE_ONE  = PHASE_BITS'(1) << FRAC_BITS;
   localparam logic [PHASE_BITS-1:0] PHASE_MAX  = '1;
   localparam logic [PHASE_BITS-1:0] STEP_RESET = PHASE_ONE;

   // Register indexes, taken from the word address bit.
   localparam logic REG_PHASE_STEP = 1'b0;
   localparam logic REG_MONO_INPUT = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
      logic                          restart;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_left;
      logic signed [SAMPLE_BITS-1:0] out_right;
      logic                          last_of_run;
   } rsp_word_type;

   // A classified frame waiting in the queue.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] cur_left;
      logic signed [SAMPLE_BITS-1:0] cur_right;
      logic                          restart;
   } qent_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase_step;
      logic                  mono_input;
   } cfg_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_stat_type;

endpackage

`default_nettype wire

### design/lirs_front.sv
// ---------------------------------------------------------------------------
// Resampler front end
// Accepts input words, applies the mono setting and hands frames to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module lirs_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lirs_pkg::cfg_type     cfg,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire lirs_pkg::req_word_type req_word,
   input  wire lirs_pkg::q_stat_type  q_stat,
   output logic                       q_push,
   output lirs_pkg::qent_type         q_data
);

   logic               hold_valid_ff;
   logic               hold_valid_in;
   lirs_pkg::qent_type hold_ent_ff;
   lirs_pkg::qent_type hold_ent_in;
   logic               accept;

   // The holding stage stalls the input only while it holds a frame and the queue is full.
   assign req_stall = hold_valid_ff && q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = hold_valid_ff && !q_stat.full;
   assign q_data    = hold_ent_ff;

   // Classify the word: in mono mode the left sample feeds both channels.
   always_comb begin
      hold_ent_in.cur_left  = req_word.left_sample;
      hold_ent_in.cur_right = cfg.mono_input ? req_word.left_sample : req_word.right_sample;
      hold_ent_in.restart   = req_word.restart;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (q_push) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   // Holding stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      if (accept) begin
         hold_ent_ff <= hold_ent_in;
      end
   end

endmodule

`default_nettype wire

### design/lirs_queue.sv
// ---------------------------------------------------------------------------
// Resampler frame queue
// Two-entry queue between the front end and the interpolation back end.
// ---------------------------------------------------------------------------
`default_nettype none

module lirs_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_push,
   input  wire lirs_pkg::qent_type   q_data,
   input  wire logic                 q_pop,
   output lirs_pkg::qent_type        q_head,
   output lirs_pkg::q_stat_type      q_stat
);

   lirs_pkg::qent_type entries_ff [2];
   logic               wr_ptr_ff;
   logic               wr_ptr_in;
   logic               rd_ptr_ff;
   logic               rd_ptr_in;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;

   assign q_head        = entries_ff[rd_ptr_ff];
   assign q_stat.not_empty = (count_ff != 2'd0);
   assign q_stat.full      = (count_ff == 2'd2);

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = q_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(q_push) - 2'(q_pop);
   end

   // Storage and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (q_push) begin
         entries_ff[wr_ptr_ff] <= q_data;
      end
   end

endmodule

`default_nettype wire

### design/lirs_back.sv
// ---------------------------------------------------------------------------
// Resampler back end
// Holds the previous frame and the phase, and emits one interpolated output
// word per cycle into the output register while running and not stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module lirs_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lirs_pkg::cfg_type     cfg,
   input  wire lirs_pkg::qent_type    q_head,
   input  wire lirs_pkg::q_stat_type  q_stat,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lirs_pkg::rsp_word_type     rsp_word
);

   localparam int SB = lirs_pkg::SAMPLE_BITS;
   localparam int FB = lirs_pkg::FRAC_BITS;
   localparam int PB = lirs_pkg::PHASE_BITS;
   localparam int CB = lirs_pkg::CNT_BITS;
   localparam int PROD_BITS = SB + FB + 2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } back_state_type;

   back_state_type         state_ff;
   back_state_type         state_in;
   logic                   have_held_ff;
   logic                   have_held_in;
   logic signed [SB-1:0]   held_l_ff;
   logic signed [SB-1:0]   held_l_in;
   logic signed [SB-1:0]   held_r_ff;
   logic signed [SB-1:0]   held_r_in;
   logic [PB-1:0]          phase_ff;
   logic [PB-1:0]          phase_in;
   logic signed [SB-1:0]   cur_l_ff;
   logic signed [SB-1:0]   cur_l_in;
   logic signed [SB-1:0]   cur_r_ff;
   logic signed [SB-1:0]   cur_r_in;
   logic [PB-1:0]          ph_ff;
   logic [PB-1:0]          ph_in;
   logic [CB-1:0]          cnt_ff;
   logic [CB-1:0]          cnt_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   lirs_pkg::rsp_word_type rsp_word_ff;
   lirs_pkg::rsp_word_type rsp_word_in;

   logic                   out_free;
   logic                   emit;
   logic                   pop_hv;
   logic [PB-1:0]          pop_phase;
   logic [PB:0]            ph_sum;
   logic [PB-1:0]          ph_next;
   logic                   run_last;
   logic signed [SB-1:0]   prev_r;
   logic signed [SB:0]     diff_l;
   logic signed [SB:0]     diff_r;
   logic signed [FB:0]     frac_s;
   logic signed [PROD_BITS-1:0] prod_l;
   logic signed [PROD_BITS-1:0] prod_r;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The output register frees up when empty or when its word is taken.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == ST_IDLE) && q_stat.not_empty;
   assign emit     = (state_ff == ST_RUN) && out_free;

   // A restart discards the held frame and zeroes the phase.
   assign pop_hv    = have_held_ff && !q_head.restart;
   assign pop_phase = q_head.restart ? '0 : phase_ff;

   // Phase advance with saturation at the top of its range.
   assign ph_sum   = {1'b0, ph_ff} + {1'b0, cfg.phase_step};
   assign ph_next  = ph_sum[PB] ? lirs_pkg::PHASE_MAX : ph_sum[PB-1:0];
   assign run_last = (ph_next >= lirs_pkg::PHASE_ONE) ||
                     (cnt_ff == CB'(lirs_pkg::MAX_OUTS - 1));

   // Interpolation datapath: held + floor((cur - held) * frac / 2^FRAC_BITS).
   always_comb begin
      prev_r = cfg.mono_input ? held_l_ff : held_r_ff;
      diff_l = (SB+1)'(cur_l_ff) - (SB+1)'(held_l_ff);
      diff_r = (SB+1)'(cur_r_ff) - (SB+1)'(prev_r);
      frac_s = $signed({1'b0, ph_ff[FB-1:0]});
      prod_l = diff_l * frac_s;
      prod_r = diff_r * frac_s;
      rsp_word_in.out_left    = held_l_ff + prod_l[SB+FB-1:FB];
      rsp_word_in.out_right   = prev_r + prod_r[SB+FB-1:FB];
      rsp_word_in.last_of_run = run_last;
   end

   // Sequencer: take a frame from the queue, then store it, skip it or run its outputs.
   always_comb begin
      state_in     = state_ff;
      have_held_in = have_held_ff;
      held_l_in    = held_l_ff;
      held_r_in    = held_r_ff;
      phase_in     = phase_ff;
      cur_l_in     = cur_l_ff;
      cur_r_in     = cur_r_ff;
      ph_in        = ph_ff;
      cnt_in       = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               priority if (!pop_hv) begin
                  // No frame held: store this one and give no output.
                  held_l_in    = q_head.cur_left;
                  held_r_in    = q_head.cur_right;
                  have_held_in = 1'b1;
                  phase_in     = pop_phase;
               end else if (pop_phase >= lirs_pkg::PHASE_ONE) begin
                  // Phase already past this frame: skip it.
                  held_l_in = q_head.cur_left;
                  held_r_in = q_head.cur_right;
                  phase_in  = pop_phase - lirs_pkg::PHASE_ONE;
               end else begin
                  cur_l_in = q_head.cur_left;
                  cur_r_in = q_head.cur_right;
                  ph_in    = pop_phase;
                  cnt_in   = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (emit) begin
               if (run_last) begin
                  phase_in  = (ph_next >= lirs_pkg::PHASE_ONE) ?
                              ph_next - lirs_pkg::PHASE_ONE : '0;
                  held_l_in = cur_l_ff;
                  held_r_in = cur_r_ff;
                  state_in  = ST_IDLE;
               end else begin
                  ph_in  = ph_next;
                  cnt_in = cnt_ff + CB'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register valid.
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_held_ff <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_held_ff <= have_held_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_l_ff <= held_l_in;
      held_r_ff <= held_r_in;
      cur_l_ff  <= cur_l_in;
      cur_r_ff  <= cur_r_in;
      ph_ff     <= ph_in;
      cnt_ff    <= cnt_in;
      if (emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

`default_nettype wire

### design/linear_interp_resampler_top.sv
// ---------------------------------------------------------------------------
// Linear interpolation resampler
// Converts input frames, at a rate set by the phase step, to stereo output words.
// ---------------------------------------------------------------------------
// Each input word is one audio frame. A frame that gives no output (first
// frame after reset or restart, or a frame skipped because the phase is
// already past it) is only popped. A frame that gives N outputs (one to six)
// is popped and then has them formed in turn, since a single interpolation
// datapath forms one output word per cycle unless the output is stalled. A
// two-entry queue behind the input register lets frames keep arriving while
// outputs are produced or stalled. Configuration is written through the
// register port at byte 0 (phase_step) and byte 4 (mono_input); the user must
// write it only while the block is idle, as the block does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module linear_interp_resampler_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [lirs_pkg::ADDR_BITS-1:0]      paddr,
   input  wire logic [lirs_pkg::DATA_BITS-1:0]      pwdata,
   output logic [lirs_pkg::DATA_BITS-1:0]           prdata,
   output logic                                     pready,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire lirs_pkg::req_word_type              req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output lirs_pkg::rsp_word_type                   rsp_word
);

   localparam int PB = lirs_pkg::PHASE_BITS;
   localparam int DB = lirs_pkg::DATA_BITS;

   lirs_pkg::cfg_type    cfg_ff;
   lirs_pkg::cfg_type    cfg_in;
   logic                 reg_idx;
   logic                 cfg_write;
   logic                 q_push;
   logic                 q_pop;
   lirs_pkg::qent_type   q_data;
   lirs_pkg::qent_type   q_head;
   lirs_pkg::q_stat_type q_stat;

   // Register port: always ready, word address selects the register.
   assign pready    = 1'b1;
   assign reg_idx   = paddr[lirs_pkg::ADDR_BITS-1];
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (reg_idx)
            lirs_pkg::REG_PHASE_STEP: cfg_in.phase_step = pwdata[PB-1:0];
            lirs_pkg::REG_MONO_INPUT: cfg_in.mono_input = pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Read data.
   always_comb begin
      unique case (reg_idx)
         lirs_pkg::REG_PHASE_STEP: prdata = DB'(cfg_ff.phase_step);
         lirs_pkg::REG_MONO_INPUT: prdata = DB'(cfg_ff.mono_input);
         default: prdata = '0;
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step <= lirs_pkg::STEP_RESET;
         cfg_ff.mono_input <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lirs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   lirs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_data (q_data),
      .q_pop  (q_pop),
      .q_head (q_head),
      .q_stat (q_stat)
   );

   lirs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_head    (q_head),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // The front end never pushes into a full queue, and the back end never
   // pops an empty one.
   `ASSERT_IMPLIES(a_no_overflow, q_push, !q_stat.full, "push into full queue")
   `ASSERT_NEVER(a_no_underflow, q_pop && !q_stat.not_empty, "pop from empty queue")

endmodule

`default_nettype wire
